### hw/rtl/sem_pkg.sv
// sobel edge magnitude package: sizes, register indexes, shared types and helpers
// used by every module of the block but sem_ram; depends on nothing
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CNT_W  = COL_W + 1;
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int ACC_W  = PIX_W + 2;
  localparam int GRAD_W = PIX_W + 3;
  localparam int SUM_W  = 2 * GRAD_W - 1;
  localparam int SQ_N   = PIX_W;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
  } dims_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } grad_t;

  // weighted 1,2,1 sum of three pixels
  function automatic logic [ACC_W-1:0] wsum(pix_t a, pix_t b, pix_t c);
    return ACC_W'(a) + ACC_W'({b, 1'b0}) + ACC_W'(c);
  endfunction

  function automatic logic [WID_W-1:0] clamp_width(logic [CFG_W-1:0] v);
    if (v == '0) return WID_W'(1);
    else if (32'(v) > 32'(MAX_WIDTH)) return WID_W'(MAX_WIDTH);
    else return WID_W'(v);
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(logic [CFG_W-1:0] v);
    if (v == '0) return HGT_W'(1);
    else if (32'(v) > 32'(MAX_HEIGHT)) return HGT_W'(MAX_HEIGHT);
    else return HGT_W'(v);
  endfunction

endpackage

### hw/rtl/sobel_edge_magnitude_top.sv
// sobel edge magnitude top level: configuration registers, pipeline advance and outputs
// depends on sem_pkg, sem_front and sem_mag
//
//   channel   ports                                  direction
//   input     in_valid in_stall in_cmd in_pixel      item in, stall out
//   result    out_valid out_stall out_edge_value     item out, stall in
//             out_last_of_frame
//   config    cfg_we cfg_index cfg_wdata             write only
//
// one item per clock while no held result stalls the pipeline; the line store
// read-modify-write with bypass sets that figure; the result for the item completing
// a neighbourhood passes the line store stage, gradient, sum of squares and root registers
// a held, untaken result freezes the whole pipeline and raises in_stall
// reset clears counters, window and pipeline valids; line stores are not cleared
// a write to the width or height register restarts the frame
module sobel_edge_magnitude_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [sem_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sem_pkg::PIX_W-1:0]      out_edge_value,
  output logic                           out_last_of_frame,
  input  logic                           cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]      cfg_wdata
);
  import sem_pkg::*;

  logic [CFG_W-1:0] width_r, height_r;
  logic             restart, adv, grad_vld;
  dims_t            dims;
  grad_t            grad;

  assign restart = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(MAX_WIDTH);
      height_r <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dims.width  = clamp_width(width_r);
  assign dims.height = clamp_height(height_r);

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  sem_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .restart  (restart),
    .dims     (dims),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_pixel (in_pixel),
    .grad_vld (grad_vld),
    .grad     (grad)
  );

  sem_mag u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .grad_vld (grad_vld),
    .grad     (grad),
    .mag_vld  (out_valid),
    .mag      (out_edge_value),
    .mag_last (out_last_of_frame)
  );

endmodule

### hw/rtl/sem_ram.sv
// generic single write port, single read port ram with registered read data
// no package dependency
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/sem_front.sv
// raster counters, line store read-modify-write and 3x3 window, producing gx and gy
// depends on sem_pkg and sem_ram
module sem_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                restart,
  input  sem_pkg::dims_t      dims,
  input  logic                in_valid,
  input  logic                in_cmd,
  input  sem_pkg::pix_t       in_pixel,
  output logic                grad_vld,
  output sem_pkg::grad_t      grad
);
  import sem_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_inc;
  logic             acc, ignore, acc_go;
  logic             emit_mid, emit_wrap, last_pos, left_zero;
  pix_t             pix_in;

  logic             s1_vld_r, s1_up_en_r, s1_md_en_r, s1_emit_r, s1_wrap_r;
  logic             s1_lz_r, s1_last_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t             s1_pix_r;

  logic                 byp_r;
  logic [2*PIX_W-1:0]   byp_data_r;
  logic [2*PIX_W-1:0]   ram_rdata, mem_q, ram_wdata;
  logic                 ram_we;
  pix_t                 up_raw, md_raw, up_px, md_px;

  pix_t win_r   [0:2][0:2];
  pix_t win_nxt [0:2][0:2];
  pix_t sel     [0:2][0:2];

  logic signed [GRAD_W-1:0] gx, gy;
  logic                     grad_vld_r;
  grad_t                    grad_r;

  // item acceptance and position decode
  assign acc       = in_valid && adv;
  assign ignore    = in_cmd && (row_r == '0) && (col_r == '0);
  assign acc_go    = acc && !ignore;
  assign pix_in    = (!in_cmd && (row_r < ROW_W'(dims.height))) ? in_pixel : '0;
  assign col_inc   = {1'b0, col_r} + CNT_W'(1);
  assign emit_mid  = (col_r != '0) && (row_r != '0);
  assign emit_wrap = (col_r == '0) && (row_r >= ROW_W'(2));
  assign last_pos  = (col_r == '0) && (row_r == ROW_W'(dims.height) + ROW_W'(1));
  assign left_zero = emit_mid ? (col_r == COL_W'(1)) : (dims.width == WID_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_pos) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= CNT_W'(dims.width)) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc_go) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store: upper line in the high byte, middle line in the low byte
  sem_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (acc_go),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign mem_q     = byp_r ? byp_data_r : ram_rdata;
  assign up_raw    = mem_q[2*PIX_W-1:PIX_W];
  assign md_raw    = mem_q[PIX_W-1:0];
  assign up_px     = s1_up_en_r ? up_raw : '0;
  assign md_px     = s1_md_en_r ? md_raw : '0;
  assign ram_we    = s1_vld_r && adv;
  assign ram_wdata = {md_raw, s1_pix_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (acc_go) begin
      byp_r <= s1_vld_r && (col_r == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go) begin
      byp_data_r <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc_go;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go) begin
      s1_col_r   <= col_r;
      s1_pix_r   <= pix_in;
      s1_up_en_r <= row_r >= ROW_W'(2);
      s1_md_en_r <= row_r != '0;
      s1_emit_r  <= emit_mid || emit_wrap;
      s1_wrap_r  <= emit_wrap;
      s1_lz_r    <= left_zero;
      s1_last_r  <= last_pos;
    end
  end

  // window shift and neighbourhood selection
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = up_px;
    win_nxt[1][2] = md_px;
    win_nxt[2][2] = s1_pix_r;
    for (int i = 0; i < 3; i++) begin
      if (s1_wrap_r) begin
        sel[i][0] = win_r[i][1];
        sel[i][1] = win_r[i][2];
        sel[i][2] = '0;
      end else begin
        sel[i][0] = win_nxt[i][0];
        sel[i][1] = win_nxt[i][1];
        sel[i][2] = win_nxt[i][2];
      end
      if (s1_lz_r) begin
        sel[i][0] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_vld_r && adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= s1_last_r ? '0 : win_nxt[i][j];
        end
      end
    end
  end

  assign gx = $signed({1'b0, wsum(sel[2][0], sel[2][1], sel[2][2])})
            - $signed({1'b0, wsum(sel[0][0], sel[0][1], sel[0][2])});
  assign gy = $signed({1'b0, wsum(sel[0][2], sel[1][2], sel[2][2])})
            - $signed({1'b0, wsum(sel[0][0], sel[1][0], sel[2][0])});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_vld_r <= 1'b0;
    end else if (adv) begin
      grad_vld_r <= s1_vld_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grad_r.gx   <= gx;
      grad_r.gy   <= gy;
      grad_r.last <= s1_last_r;
    end
  end

  assign grad_vld = grad_vld_r;
  assign grad     = grad_r;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < CNT_W'(dims.width))
    else $error("column count beyond row width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(dims.height) + ROW_W'(1))
    else $error("row count beyond frame end");

  a_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_go && s1_vld_r && (col_r == s1_col_r)) |->
      ((dims.width == WID_W'(1)) || s1_last_r))
    else $error("unexpected back to back access to one line store entry");

endmodule

### hw/rtl/sem_mag.sv
// gradient magnitude: sum of squares, then one root bit per pipeline stage
// depends on sem_pkg
module sem_mag (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           grad_vld,
  input  sem_pkg::grad_t grad,
  output logic           mag_vld,
  output sem_pkg::pix_t  mag,
  output logic           mag_last
);
  import sem_pkg::*;

  logic signed [2*GRAD_W-1:0] sqx, sqy;
  logic [SUM_W-1:0]           sum;

  logic               vld_r [0:SQ_N];
  logic               sat_r [0:SQ_N];
  logic               lt_r  [0:SQ_N];
  logic [2*PIX_W-1:0] sm_r  [0:SQ_N-1];
  pix_t               rt_r  [1:SQ_N];

  assign sqx = grad.gx * grad.gx;
  assign sqy = grad.gy * grad.gy;
  assign sum = sqx[SUM_W-1:0] + sqy[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= grad_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_r[0]  <= sum[2*PIX_W-1:0];
      sat_r[0] <= |sum[SUM_W-1:2*PIX_W];
      lt_r[0]  <= grad.last;
    end
  end

  for (genvar i = 1; i <= SQ_N; i++) begin : g_root
    pix_t               prev, trial;
    logic [2*PIX_W-1:0] trial_sq;

    if (i == 1) begin : g_first
      assign prev = '0;
    end else begin : g_next
      assign prev = rt_r[i-1];
    end

    assign trial    = prev | PIX_W'(1 << (SQ_N - i));
    assign trial_sq = trial * trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_r[i]  <= (trial_sq <= sm_r[i-1]) ? trial : prev;
        sat_r[i] <= sat_r[i-1];
        lt_r[i]  <= lt_r[i-1];
      end
    end

    if (i < SQ_N) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          sm_r[i] <= sm_r[i-1];
        end
      end
    end
  end

  assign mag_vld  = vld_r[SQ_N];
  assign mag      = sat_r[SQ_N] ? '1 : rt_r[SQ_N];
  assign mag_last = lt_r[SQ_N];

endmodule
